>>> sv/svalloc_pkg.sv
// shared types and constants of the voice allocator
// used by svalloc_front, svalloc_back and synth_voice_allocator_top; no dependencies
package svalloc_pkg;

  localparam int NUM_VOICES  = 16;
  localparam int VOICE_W     = 4;
  localparam int NUM_LAYERS  = 4;
  localparam int LAYER_W     = 2;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int CHAN_W      = 5;
  localparam int FUNC_W      = 2;
  localparam int LCOUNT_W    = 3;
  localparam int AGE_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int PADDR_W     = 5;
  localparam int REG_IDX_W   = 3;
  localparam int PDATA_W     = 32;

  localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALL_OFF  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FINISH   = 2'd3;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_PROGRAM_LOADED = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAYER_COUNT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAYER0_CHANNEL = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LAYER1_CHANNEL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LAYER2_CHANNEL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LAYER3_CHANNEL = 3'd5;

  typedef enum logic [1:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_ALL_OFF,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ON_LAYER,
    ST_ON_SCAN,
    ST_OFF_SCAN,
    ST_ALL_SCAN,
    ST_FLUSH
  } back_state_t;

  typedef struct packed {
    logic                                 loaded;
    logic [LCOUNT_W-1:0]                  layer_count;
    logic [NUM_LAYERS-1:0][CHAN_W-1:0]    chan;
  } cfg_t;

  typedef struct packed {
    op_t                   op;
    logic [NOTE_W-1:0]     note;
    logic [VEL_W-1:0]      vel;
    logic [CHAN_W-1:0]     chan;
    logic [NUM_LAYERS-1:0] match;
    logic [VOICE_W-1:0]    fin;
  } item_t;

  typedef struct packed {
    logic               command;
    logic [VOICE_W-1:0] voice;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   vel;
    logic [LAYER_W-1:0] layer;
  } result_t;

endpackage

>>> sv/svalloc_front.sv
// front end: accepts items, classifies them and queues them for the back end
// depends on svalloc_pkg
module svalloc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  svalloc_pkg::cfg_t              cfg,
  input  logic                           start,
  output logic                           busy,
  input  logic [svalloc_pkg::FUNC_W-1:0] in_func,
  input  logic [svalloc_pkg::NOTE_W-1:0] in_key_number,
  input  logic [svalloc_pkg::VEL_W-1:0]  in_key_velocity,
  input  logic [svalloc_pkg::CHAN_W-1:0] in_midi_channel,
  input  logic [svalloc_pkg::NUM_LAYERS-1:0] in_layer_match,
  input  logic [svalloc_pkg::VOICE_W-1:0] in_finished_voice,
  output svalloc_pkg::item_t             head,
  output logic                           head_valid,
  input  logic                           pop
);

  svalloc_pkg::item_t                  item_in;
  logic                                keep;
  logic                                push;
  logic [svalloc_pkg::NUM_LAYERS-1:0]  layer_mask;

  svalloc_pkg::item_t                  q_r [svalloc_pkg::QUEUE_DEPTH];
  logic [svalloc_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [svalloc_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [svalloc_pkg::QPTR_W:0]        count_r;

  // layers beyond the loaded count never match
  always_comb begin
    for (int l = 0; l < svalloc_pkg::NUM_LAYERS; l++) begin
      layer_mask[l] = svalloc_pkg::LCOUNT_W'(l) < cfg.layer_count;
    end
  end

  always_comb begin
    item_in.note  = in_key_number;
    item_in.vel   = in_key_velocity;
    item_in.chan  = in_midi_channel;
    item_in.match = in_layer_match & layer_mask;
    item_in.fin   = in_finished_voice;
    unique case (in_func)
      svalloc_pkg::FUNC_NOTE_ON:  item_in.op = svalloc_pkg::OP_NOTE_ON;
      svalloc_pkg::FUNC_NOTE_OFF: item_in.op = svalloc_pkg::OP_NOTE_OFF;
      svalloc_pkg::FUNC_ALL_OFF:  item_in.op = svalloc_pkg::OP_ALL_OFF;
      default:                    item_in.op = svalloc_pkg::OP_FINISH;
    endcase
    // note events without a program are dropped here
    keep = cfg.loaded || (in_func == svalloc_pkg::FUNC_ALL_OFF) ||
           (in_func == svalloc_pkg::FUNC_FINISH);
  end

  assign busy       = (count_r == (svalloc_pkg::QPTR_W+1)'(svalloc_pkg::QUEUE_DEPTH));
  assign push       = start && !busy && keep;
  assign head       = q_r[rd_ptr_r];
  assign head_valid = (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (svalloc_pkg::QPTR_W+1)'(svalloc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

>>> sv/svalloc_back.sv
// back end: voice state, allocation and release sequencer, result register
// depends on svalloc_pkg; takes items from svalloc_front
module svalloc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  svalloc_pkg::cfg_t               cfg,
  input  svalloc_pkg::item_t              head,
  input  logic                            head_valid,
  output logic                            pop,
  output logic                            out_strobe,
  output logic                            out_command,
  output logic [svalloc_pkg::VOICE_W-1:0] out_voice_id,
  output logic [svalloc_pkg::NOTE_W-1:0]  out_voice_note,
  output logic [svalloc_pkg::VEL_W-1:0]   out_voice_velocity,
  output logic [svalloc_pkg::LAYER_W-1:0] out_voice_layer,
  output logic                            out_last_command
);

  svalloc_pkg::back_state_t state_r, state_nxt;

  svalloc_pkg::item_t                  item_r;
  logic [svalloc_pkg::NUM_LAYERS-1:0]  match_r;
  logic [svalloc_pkg::VOICE_W-1:0]     idx_r;
  logic [svalloc_pkg::VOICE_W-1:0]     best_r;
  logic [svalloc_pkg::AGE_W-1:0]       best_age_r;

  logic [svalloc_pkg::NUM_VOICES-1:0]  active_r;
  logic [svalloc_pkg::NUM_VOICES-1:0]  lvalid_r;
  logic [svalloc_pkg::NOTE_W-1:0]      note_r  [svalloc_pkg::NUM_VOICES];
  logic [svalloc_pkg::LAYER_W-1:0]     layer_r [svalloc_pkg::NUM_VOICES];
  logic [svalloc_pkg::AGE_W-1:0]       age_r   [svalloc_pkg::NUM_VOICES];
  logic [svalloc_pkg::AGE_W-1:0]       age_ctr_r;

  logic                                pend_valid_r;
  svalloc_pkg::result_t                pend_r;
  logic                                out_strobe_r;
  svalloc_pkg::result_t                out_res_r;
  logic                                out_last_r;

  logic                                free_any;
  logic [svalloc_pkg::VOICE_W-1:0]     free_voice;
  logic [svalloc_pkg::LAYER_W-1:0]     cur_layer;
  logic [svalloc_pkg::AGE_W-1:0]       scan_age;
  logic                                scan_lower;
  logic                                scan_last;
  logic [svalloc_pkg::VOICE_W-1:0]     steal_voice;
  logic [svalloc_pkg::CHAN_W-1:0]      scan_chan;
  logic                                off_hit;
  logic [svalloc_pkg::AGE_W-1:0]       age_next;

  logic                                assign_en;
  logic [svalloc_pkg::VOICE_W-1:0]     assign_voice;
  logic                                new_en;
  svalloc_pkg::result_t                new_res;
  logic                                flush;
  logic                                emit;

  always_comb begin
    free_voice = '0;
    for (int v = svalloc_pkg::NUM_VOICES - 1; v >= 0; v--) begin
      if (!active_r[v]) begin
        free_voice = svalloc_pkg::VOICE_W'(v);
      end
    end
    cur_layer = '0;
    for (int l = svalloc_pkg::NUM_LAYERS - 1; l >= 0; l--) begin
      if (match_r[l]) begin
        cur_layer = svalloc_pkg::LAYER_W'(l);
      end
    end
  end

  assign free_any    = !(&active_r);
  assign scan_age    = age_r[idx_r];
  assign scan_lower  = scan_age < best_age_r;
  assign scan_last   = (idx_r == svalloc_pkg::VOICE_W'(svalloc_pkg::NUM_VOICES - 1));
  assign steal_voice = scan_lower ? idx_r : best_r;
  assign scan_chan   = cfg.chan[layer_r[idx_r]];
  assign off_hit     = active_r[idx_r] && lvalid_r[idx_r] && (note_r[idx_r] == item_r.note) &&
                       ((scan_chan == '0) || (scan_chan == item_r.chan));
  assign age_next    = age_ctr_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svalloc_pkg::ST_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            svalloc_pkg::OP_NOTE_ON:  state_nxt = svalloc_pkg::ST_ON_LAYER;
            svalloc_pkg::OP_NOTE_OFF: state_nxt = svalloc_pkg::ST_OFF_SCAN;
            svalloc_pkg::OP_ALL_OFF:  state_nxt = svalloc_pkg::ST_ALL_SCAN;
            default:                  state_nxt = svalloc_pkg::ST_IDLE;
          endcase
        end
      end
      svalloc_pkg::ST_ON_LAYER: begin
        if (match_r == '0) begin
          state_nxt = svalloc_pkg::ST_FLUSH;
        end else if (!free_any) begin
          state_nxt = svalloc_pkg::ST_ON_SCAN;
        end
      end
      svalloc_pkg::ST_ON_SCAN: begin
        if (scan_last) begin
          state_nxt = svalloc_pkg::ST_ON_LAYER;
        end
      end
      svalloc_pkg::ST_OFF_SCAN,
      svalloc_pkg::ST_ALL_SCAN: begin
        if (scan_last) begin
          state_nxt = svalloc_pkg::ST_FLUSH;
        end
      end
      svalloc_pkg::ST_FLUSH: state_nxt = svalloc_pkg::ST_IDLE;
      default:               state_nxt = svalloc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop          = 1'b0;
    assign_en    = 1'b0;
    assign_voice = free_voice;
    new_en       = 1'b0;
    flush        = 1'b0;
    new_res      = '{command: svalloc_pkg::CMD_RELEASE, voice: idx_r,
                     note: '0, vel: '0, layer: '0};
    unique case (state_r)
      svalloc_pkg::ST_IDLE:     pop = head_valid;
      svalloc_pkg::ST_ON_LAYER: assign_en = (match_r != '0) && free_any;
      svalloc_pkg::ST_ON_SCAN: begin
        assign_en    = scan_last;
        assign_voice = steal_voice;
      end
      svalloc_pkg::ST_OFF_SCAN: new_en = off_hit;
      svalloc_pkg::ST_ALL_SCAN: new_en = 1'b1;
      svalloc_pkg::ST_FLUSH:    flush = 1'b1;
      default: ;
    endcase
    if (assign_en) begin
      new_en  = 1'b1;
      new_res = '{command: svalloc_pkg::CMD_START, voice: assign_voice,
                  note: item_r.note, vel: item_r.vel, layer: cur_layer};
    end
  end

  // one result is held back so the last one of an item can be marked
  assign emit = pend_valid_r && (new_en || flush);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= svalloc_pkg::ST_IDLE;
      idx_r        <= '0;
      match_r      <= '0;
      active_r     <= '0;
      lvalid_r     <= '0;
      age_ctr_r    <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      for (int v = 0; v < svalloc_pkg::NUM_VOICES; v++) begin
        note_r[v]  <= '0;
        layer_r[v] <= '0;
        age_r[v]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        match_r <= head.match;
        idx_r   <= '0;
        if (head.op == svalloc_pkg::OP_FINISH) begin
          active_r[head.fin] <= 1'b0;
        end
      end
      if ((state_r == svalloc_pkg::ST_ON_LAYER) && (match_r != '0) && !free_any) begin
        idx_r <= svalloc_pkg::VOICE_W'(1);
      end
      if ((state_r == svalloc_pkg::ST_ON_SCAN) || (state_r == svalloc_pkg::ST_OFF_SCAN) ||
          (state_r == svalloc_pkg::ST_ALL_SCAN)) begin
        idx_r <= idx_r + 1'b1;
      end
      if (assign_en) begin
        active_r[assign_voice] <= 1'b1;
        lvalid_r[assign_voice] <= 1'b1;
        note_r[assign_voice]   <= item_r.note;
        layer_r[assign_voice]  <= cur_layer;
        age_r[assign_voice]    <= age_next;
        age_ctr_r              <= age_next;
        match_r                <= match_r & (match_r - 1'b1);
      end
      if (new_en) begin
        pend_valid_r <= 1'b1;
      end else if (flush) begin
        pend_valid_r <= 1'b0;
      end
      out_strobe_r <= emit;
      out_last_r   <= flush && pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
    if ((state_r == svalloc_pkg::ST_ON_LAYER) && (match_r != '0) && !free_any) begin
      best_r     <= '0;
      best_age_r <= age_r[0];
    end else if ((state_r == svalloc_pkg::ST_ON_SCAN) && scan_lower) begin
      best_r     <= idx_r;
      best_age_r <= scan_age;
    end
    if (new_en) begin
      pend_r <= new_res;
    end
    if (emit) begin
      out_res_r <= pend_r;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_command        = out_res_r.command;
  assign out_voice_id       = out_res_r.voice;
  assign out_voice_note     = out_res_r.note;
  assign out_voice_velocity = out_res_r.vel;
  assign out_voice_layer    = out_res_r.layer;
  assign out_last_command   = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svalloc_pkg::ST_IDLE) |-> !pend_valid_r)
    else $error("result left pending between items");

  a_steal_all_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svalloc_pkg::ST_ON_SCAN) |-> (&active_r))
    else $error("age scan while a voice is free");

  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_strobe_r)
    else $error("last marker without a result");

  a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
    assign_en |=> (age_ctr_r == $past(age_ctr_r) + 1'b1))
    else $error("age counter did not advance on allocation");

endmodule

>>> sv/synth_voice_allocator_top.sv
// Polyphonic voice allocator with oldest-voice stealing. An item is taken when start is
// high and busy is low; a two-entry queue sits in front of the sequencer, so busy rises
// only while two items wait. The sequencer first takes an item from the queue, and voice
// finished needs nothing more. Note on then assigns one voice per matching layer, taken
// from the free voices while one is free and found by an age search when one must be
// stolen; the search reads one voice per cycle. The item then closes. Note off and all
// notes off scan the sixteen voices at one per cycle and then close the item. Results
// leave at most one per cycle on out_strobe; each is held back until the next one is made
// or the item closes. The receiver cannot hold results off. Registers sit on an APB port
// at byte offsets 4*i.
// depends on svalloc_pkg, svalloc_front, svalloc_back
module synth_voice_allocator_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [svalloc_pkg::PADDR_W-1:0]      paddr,
  input  logic [svalloc_pkg::PDATA_W-1:0]      pwdata,
  output logic [svalloc_pkg::PDATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [svalloc_pkg::FUNC_W-1:0]       in_func,
  input  logic [svalloc_pkg::NOTE_W-1:0]       in_key_number,
  input  logic [svalloc_pkg::VEL_W-1:0]        in_key_velocity,
  input  logic [svalloc_pkg::CHAN_W-1:0]       in_midi_channel,
  input  logic [svalloc_pkg::NUM_LAYERS-1:0]   in_layer_match,
  input  logic [svalloc_pkg::VOICE_W-1:0]      in_finished_voice,
  output logic                                 out_strobe,
  output logic                                 out_command,
  output logic [svalloc_pkg::VOICE_W-1:0]      out_voice_id,
  output logic [svalloc_pkg::NOTE_W-1:0]       out_voice_note,
  output logic [svalloc_pkg::VEL_W-1:0]        out_voice_velocity,
  output logic [svalloc_pkg::LAYER_W-1:0]      out_voice_layer,
  output logic                                 out_last_command
);

  svalloc_pkg::cfg_t                   cfg_r;
  logic                                wr_en;
  logic [svalloc_pkg::REG_IDX_W-1:0]   reg_idx;
  svalloc_pkg::item_t                  head;
  logic                                head_valid;
  logic                                pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[svalloc_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        svalloc_pkg::REG_PROGRAM_LOADED: cfg_r.loaded      <= pwdata[0];
        svalloc_pkg::REG_LAYER_COUNT:    cfg_r.layer_count <= pwdata[svalloc_pkg::LCOUNT_W-1:0];
        svalloc_pkg::REG_LAYER0_CHANNEL: cfg_r.chan[0]     <= pwdata[svalloc_pkg::CHAN_W-1:0];
        svalloc_pkg::REG_LAYER1_CHANNEL: cfg_r.chan[1]     <= pwdata[svalloc_pkg::CHAN_W-1:0];
        svalloc_pkg::REG_LAYER2_CHANNEL: cfg_r.chan[2]     <= pwdata[svalloc_pkg::CHAN_W-1:0];
        svalloc_pkg::REG_LAYER3_CHANNEL: cfg_r.chan[3]     <= pwdata[svalloc_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      svalloc_pkg::REG_PROGRAM_LOADED: prdata = svalloc_pkg::PDATA_W'(cfg_r.loaded);
      svalloc_pkg::REG_LAYER_COUNT:    prdata = svalloc_pkg::PDATA_W'(cfg_r.layer_count);
      svalloc_pkg::REG_LAYER0_CHANNEL: prdata = svalloc_pkg::PDATA_W'(cfg_r.chan[0]);
      svalloc_pkg::REG_LAYER1_CHANNEL: prdata = svalloc_pkg::PDATA_W'(cfg_r.chan[1]);
      svalloc_pkg::REG_LAYER2_CHANNEL: prdata = svalloc_pkg::PDATA_W'(cfg_r.chan[2]);
      svalloc_pkg::REG_LAYER3_CHANNEL: prdata = svalloc_pkg::PDATA_W'(cfg_r.chan[3]);
      default:                         prdata = '0;
    endcase
  end

  svalloc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_key_number     (in_key_number),
    .in_key_velocity   (in_key_velocity),
    .in_midi_channel   (in_midi_channel),
    .in_layer_match    (in_layer_match),
    .in_finished_voice (in_finished_voice),
    .head              (head),
    .head_valid        (head_valid),
    .pop               (pop)
  );

  svalloc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head               (head),
    .head_valid         (head_valid),
    .pop                (pop),
    .out_strobe         (out_strobe),
    .out_command        (out_command),
    .out_voice_id       (out_voice_id),
    .out_voice_note     (out_voice_note),
    .out_voice_velocity (out_voice_velocity),
    .out_voice_layer    (out_voice_layer),
    .out_last_command   (out_last_command)
  );

endmodule
